/* hdl/icp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icp_pkg: shared types and constants of the iteration count palette
// Register indexes, curve scale factors, the color mode decode and channel saturation.
// ----------------------------------------------------------------------------
package icp_pkg;

  typedef logic [0:0] reg_idx_t;
  typedef logic [2:0] color_mode_t;
  typedef logic [1:0] rot_t;

  localparam reg_idx_t REG_MAX_ITER   = 1'b0;
  localparam reg_idx_t REG_COLOR_MODE = 1'b1;

  localparam int CNT_FIELD_W = 16;
  localparam int CHAN_W      = 8;
  localparam int SCALED_W    = 12;

  // curve weight times 255
  localparam logic [SCALED_W-1:0] K_OUTER_SCALED = 12'd2295;
  localparam logic [SCALED_W-1:0] K_MID_SCALED   = 12'd3825;
  localparam logic [SCALED_W-1:0] CHAN_MAX       = 12'd255;

  localparam color_mode_t MODE_SWAP_BASE = 3'd3;

  localparam rot_t ROT_RED   = 2'd0;
  localparam rot_t ROT_GREEN = 2'd1;
  localparam rot_t ROT_BLUE  = 2'd2;

  function automatic rot_t mode_rotation(input color_mode_t mode);
    rot_t r;
    r = ROT_RED;
    case (mode)
      3'd0, 3'd3, 3'd6: r = ROT_RED;
      3'd1, 3'd4, 3'd7: r = ROT_GREEN;
      default:          r = ROT_BLUE;
    endcase
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] saturate(input logic [SCALED_W-1:0] v);
    logic [CHAN_W-1:0] b;
    b = (v > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : v[CHAN_W-1:0];
    return b;
  endfunction

endpackage

/* hdl/icp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icp_div: pipelined ratio divider
// Computes t = cnt * 2^FRAC_BITS / mx for cnt <= mx, one quotient bit per
// register stage (restoring division). A full count gives t = 1 exactly.
// ----------------------------------------------------------------------------
module icp_div #(
  parameter int CNT_W     = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [CNT_W-1:0]     in_cnt,
  input  logic                 in_full,
  input  logic [CNT_W-1:0]     mx,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   out_t
);

  logic                 valid [0:FRAC_BITS];
  logic                 full  [0:FRAC_BITS];
  logic [CNT_W-1:0]     rem   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] quo   [0:FRAC_BITS];
  logic                 mx_nz;

  assign mx_nz = (mx != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
    full[0] <= in_full;
    rem[0]  <= in_full ? '0 : in_cnt;
    quo[0]  <= '0;
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    logic [CNT_W:0] shl;
    logic [CNT_W:0] diff;
    logic           geq;

    assign shl  = {rem[k], 1'b0};
    assign diff = shl - {1'b0, mx};
    assign geq  = mx_nz && (shl >= {1'b0, mx});

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
      full[k+1] <= full[k];
      rem[k+1]  <= geq ? diff[CNT_W-1:0] : shl[CNT_W-1:0];
      quo[k+1]  <= {quo[k][FRAC_BITS-2:0], geq};
    end
  end

  assign out_valid = valid[FRAC_BITS];
  assign out_t     = {full[FRAC_BITS], quo[FRAC_BITS]};

endmodule

/* hdl/iteration_count_palette_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iteration_count_palette_top: escape count to 24-bit RGB color
// Pipeline: an input register and FRAC_BITS divider stages, then four
// multiply stages and the output register, which drives done.
// Throughput: one request per clock; busy is low except during reset.
// Reset (rst, synchronous): clears the pipeline valid bits, sets
// max_iterations to 100 and color_mode to 0.
// ----------------------------------------------------------------------------
module iteration_count_palette_top #(
  parameter int COUNT_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] iter_count,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = (COUNT_WIDTH < icp_pkg::CNT_FIELD_W) ?
                         COUNT_WIDTH : icp_pkg::CNT_FIELD_W;
  localparam int FX_W  = FRAC_BITS + 1;
  localparam int PR_W  = 2 * FX_W;
  localparam int SC_W  = FX_W + icp_pkg::SCALED_W;
  localparam int LAT   = FRAC_BITS + 6;
  localparam logic [FX_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [CNT_W-1:0]          max_iterations;
  icp_pkg::color_mode_t      color_mode;
  logic                      wr_en;
  icp_pkg::reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= CNT_W'(100);
      color_mode     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        icp_pkg::REG_MAX_ITER:   max_iterations <= pwdata[CNT_W-1:0];
        icp_pkg::REG_COLOR_MODE: color_mode     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      icp_pkg::REG_MAX_ITER:   prdata = 32'(max_iterations);
      icp_pkg::REG_COLOR_MODE: prdata = 32'(color_mode);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // ratio t = count / max_iterations
  logic             accept;
  logic [CNT_W-1:0] cnt;
  logic             cnt_full;
  logic             dv_valid;
  logic [FX_W-1:0]  dv_t;

  assign accept   = start && !busy;
  assign cnt      = iter_count[CNT_W-1:0];
  assign cnt_full = (max_iterations != '0) && (cnt >= max_iterations);

  icp_div #(
    .CNT_W     (CNT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_cnt    (cnt),
    .in_full   (cnt_full),
    .mx        (max_iterations),
    .out_valid (dv_valid),
    .out_t     (dv_t)
  );

  // M1: t^2, u^2
  logic            m1_valid;
  logic [FX_W-1:0] m1_t, m1_u, m1_tt, m1_uu;
  logic [FX_W-1:0] u_next;
  logic [PR_W-1:0] tt_prod, uu_prod;

  assign u_next  = ONE_FX - dv_t;
  assign tt_prod = {{FX_W{1'b0}}, dv_t} * {{FX_W{1'b0}}, dv_t};
  assign uu_prod = {{FX_W{1'b0}}, u_next} * {{FX_W{1'b0}}, u_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= dv_valid;
    end
    m1_t  <= dv_t;
    m1_u  <= u_next;
    m1_tt <= tt_prod[FRAC_BITS +: FX_W];
    m1_uu <= uu_prod[FRAC_BITS +: FX_W];
  end

  // M2: t^3, u^3, u^2 t^2
  logic            m2_valid;
  logic [FX_W-1:0] m2_t, m2_u, m2_ttt, m2_uuu, m2_uutt;
  logic [PR_W-1:0] ttt_prod, uuu_prod, uutt_prod;

  assign ttt_prod  = {{FX_W{1'b0}}, m1_tt} * {{FX_W{1'b0}}, m1_t};
  assign uuu_prod  = {{FX_W{1'b0}}, m1_uu} * {{FX_W{1'b0}}, m1_u};
  assign uutt_prod = {{FX_W{1'b0}}, m1_uu} * {{FX_W{1'b0}}, m1_tt};

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_t    <= m1_t;
    m2_u    <= m1_u;
    m2_ttt  <= ttt_prod[FRAC_BITS +: FX_W];
    m2_uuu  <= uuu_prod[FRAC_BITS +: FX_W];
    m2_uutt <= uutt_prod[FRAC_BITS +: FX_W];
  end

  // M3: curve bases
  logic            m3_valid;
  logic [FX_W-1:0] m3_pa, m3_pb, m3_pc;
  logic [PR_W-1:0] pa_prod, pc_prod;

  assign pa_prod = {{FX_W{1'b0}}, m2_ttt} * {{FX_W{1'b0}}, m2_u};
  assign pc_prod = {{FX_W{1'b0}}, m2_uuu} * {{FX_W{1'b0}}, m2_t};

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
    m3_pa <= pa_prod[FRAC_BITS +: FX_W];
    m3_pb <= m2_uutt;
    m3_pc <= pc_prod[FRAC_BITS +: FX_W];
  end

  // M4: scale to channel range
  logic                          m4_valid;
  logic [icp_pkg::SCALED_W-1:0]  m4_va, m4_vb, m4_vc;
  logic [SC_W-1:0]               va_prod, vb_prod, vc_prod;

  assign va_prod = {{icp_pkg::SCALED_W{1'b0}}, m3_pa} *
                   {{FX_W{1'b0}}, icp_pkg::K_OUTER_SCALED};
  assign vb_prod = {{icp_pkg::SCALED_W{1'b0}}, m3_pb} *
                   {{FX_W{1'b0}}, icp_pkg::K_MID_SCALED};
  assign vc_prod = {{icp_pkg::SCALED_W{1'b0}}, m3_pc} *
                   {{FX_W{1'b0}}, icp_pkg::K_OUTER_SCALED};

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else begin
      m4_valid <= m3_valid;
    end
    m4_va <= va_prod[FRAC_BITS +: icp_pkg::SCALED_W];
    m4_vb <= vb_prod[FRAC_BITS +: icp_pkg::SCALED_W];
    m4_vc <= vc_prod[FRAC_BITS +: icp_pkg::SCALED_W];
  end

  // output: saturate, swap the outer curves in modes 3 and up, and rotate onto channels
  logic [7:0]    ba, bb, bc, first, last;
  logic [7:0]    red_next, green_next, blue_next;
  icp_pkg::rot_t rot;
  logic          swap;

  assign ba   = icp_pkg::saturate(m4_va);
  assign bb   = icp_pkg::saturate(m4_vb);
  assign bc   = icp_pkg::saturate(m4_vc);
  assign swap = (color_mode >= icp_pkg::MODE_SWAP_BASE);
  assign rot  = icp_pkg::mode_rotation(color_mode);
  assign first = swap ? bc : ba;
  assign last  = swap ? ba : bc;

  always_comb begin
    red_next   = first;
    green_next = bb;
    blue_next  = last;
    unique case (rot)
      icp_pkg::ROT_RED: begin
        red_next   = first;
        green_next = bb;
        blue_next  = last;
      end
      icp_pkg::ROT_GREEN: begin
        green_next = first;
        blue_next  = bb;
        red_next   = last;
      end
      icp_pkg::ROT_BLUE: begin
        blue_next  = first;
        red_next   = bb;
        green_next = last;
      end
      default: begin
        red_next   = first;
        green_next = bb;
        blue_next  = last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m4_valid;
    end
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  // checks
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("done without a matching request");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    m1_valid |-> (m1_t <= ONE_FX))
    else $error("ratio above one");

  a_no_saturation: assert property (@(posedge clk) disable iff (rst)
    m4_valid |-> (m4_va <= icp_pkg::CHAN_MAX) && (m4_vb <= icp_pkg::CHAN_MAX) &&
                 (m4_vc <= icp_pkg::CHAN_MAX))
    else $error("curve value beyond channel range");

endmodule

/* tb/sv/tb_iteration_count_palette_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iteration_count_palette_top: self-checking bench of the palette block
// Queued requests are driven through start/busy, with APB register writes
// between phases once the pipeline has drained. Each color is predicted from
// the fixed-point Bernstein curves and checked, channel by channel, in order.
// ----------------------------------------------------------------------------
module tb_iteration_count_palette_top;

  localparam int FRAC        = 16;
  localparam int LATENCY     = FRAC + 5;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {ACT_PIXEL, ACT_WRITE, ACT_DRAIN} act_t;
  typedef enum logic [1:0] {DRV_RUN, DRV_DRAIN, DRV_ACCESS} drv_st_t;

  typedef struct packed {
    act_t               act;
    logic [15:0]        count;
    icp_pkg::reg_idx_t  idx;
    logic [31:0]        data;
    logic [3:0]         gap;
  } req_t;

  typedef struct packed {
    logic [icp_pkg::CHAN_W-1:0] r;
    logic [icp_pkg::CHAN_W-1:0] g;
    logic [icp_pkg::CHAN_W-1:0] b;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] iter_count = '0;
  logic        done;
  logic [7:0]  red, green, blue;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  req_t        req_q[$];
  rgb_t        color_q[$];
  rgb_t        want;
  drv_st_t     drv_st = DRV_RUN;
  logic [3:0]  gap_cnt = '0;
  logic [15:0] cfg_max = 16'd100;
  logic [2:0]  cfg_mode = 3'd0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  iteration_count_palette_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .iter_count(iter_count),
    .done(done), .red(red), .green(green), .blue(blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit [63:0] fx_mul(input bit [63:0] x, input bit [63:0] y);
    return (x * y) >> FRAC;
  endfunction

  function automatic logic [icp_pkg::CHAN_W-1:0] curve_byte(input bit [63:0] k,
                                                            input bit [63:0] p);
    bit [63:0] v;
    v = (k * p) >> FRAC;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic rgb_t palette_color(input logic [15:0] cnt_in);
    bit [63:0]                  cnt, mx, t, u, tt, uu;
    logic [icp_pkg::CHAN_W-1:0] ca, cb, cc, first, last;
    logic [icp_pkg::CHAN_W-1:0] ch [0:2];
    int unsigned                rot;
    cnt = 64'(cnt_in);
    mx  = 64'(cfg_max);
    if (mx == 0) begin
      t = 0;
    end else begin
      if (cnt > mx) cnt = mx;
      t = (cnt << FRAC) / mx;
    end
    u  = (64'd1 << FRAC) - t;
    tt = fx_mul(t, t);
    uu = fx_mul(u, u);
    ca = curve_byte(64'(icp_pkg::K_OUTER_SCALED), fx_mul(fx_mul(tt, t), u));
    cb = curve_byte(64'(icp_pkg::K_MID_SCALED), fx_mul(uu, tt));
    cc = curve_byte(64'(icp_pkg::K_OUTER_SCALED), fx_mul(fx_mul(uu, u), t));
    if (cfg_mode < icp_pkg::MODE_SWAP_BASE) begin
      rot   = cfg_mode;
      first = ca;
      last  = cc;
    end else begin
      rot   = (cfg_mode - icp_pkg::MODE_SWAP_BASE) % 3;
      first = cc;
      last  = ca;
    end
    ch[rot]           = first;
    ch[(rot + 1) % 3] = cb;
    ch[(rot + 2) % 3] = last;
    return '{r: ch[0], g: ch[1], b: ch[2]};
  endfunction

  // driver: requests from req_q, register writes only with nothing in flight
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      gap_cnt  <= '0;
      drv_st   <= DRV_RUN;
      cfg_max  <= 16'd100;
      cfg_mode <= 3'd0;
    end else begin
      if (start && !busy) color_q.push_back(palette_color(iter_count));
      if (psel && penable && pwrite && pready) begin
        if (icp_pkg::reg_idx_t'(paddr[2]) == icp_pkg::REG_MAX_ITER) cfg_max <= pwdata[15:0];
        else cfg_mode <= pwdata[2:0];
      end
      case (drv_st)
        DRV_RUN: begin
          if (!(start && busy)) begin
            if (gap_cnt != 0) begin
              start   <= 1'b0;
              gap_cnt <= gap_cnt - 1'b1;
            end else if (req_q.size() != 0 && req_q[0].act == ACT_PIXEL) begin
              start      <= 1'b1;
              iter_count <= req_q[0].count;
              gap_cnt    <= req_q[0].gap;
              void'(req_q.pop_front());
            end else begin
              start <= 1'b0;
              if (req_q.size() != 0) drv_st <= DRV_DRAIN;
            end
          end
        end
        DRV_DRAIN: begin
          if (color_q.size() == 0) begin
            if (req_q.size() == 0 || req_q[0].act == ACT_PIXEL) begin
              drv_st <= DRV_RUN;
            end else if (req_q[0].act == ACT_DRAIN) begin
              void'(req_q.pop_front());
              drv_st <= DRV_RUN;
            end else begin
              psel    <= 1'b1;
              penable <= 1'b0;
              pwrite  <= 1'b1;
              paddr   <= {req_q[0].idx, 2'b00};
              pwdata  <= req_q[0].data;
              drv_st  <= DRV_ACCESS;
            end
          end
        end
        DRV_ACCESS: begin
          if (!penable) begin
            penable <= 1'b1;
          end else if (pready) begin
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            void'(req_q.pop_front());
            drv_st  <= DRV_DRAIN;
          end
        end
        default: drv_st <= DRV_RUN;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (color_q.size() == 0) begin
        $display("%0t: unexpected color r=%0d g=%0d b=%0d", $time, red, green, blue);
        err_cnt++;
      end else begin
        want = color_q.pop_front();
        if (red !== want.r) begin
          $display("%0t: red expected %0d actual %0d", $time, want.r, red);
          err_cnt++;
        end
        if (green !== want.g) begin
          $display("%0t: green expected %0d actual %0d", $time, want.g, green);
          err_cnt++;
        end
        if (blue !== want.b) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.b, blue);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_iteration_count_palette_top: done, errors");
      $finish;
    end
  end

  task automatic add_pixel(input int cnt, input int gap);
    req_t q;
    q = '{act: ACT_PIXEL, count: cnt[15:0], idx: icp_pkg::REG_MAX_ITER, data: '0,
          gap: gap[3:0]};
    req_q.push_back(q);
  endtask

  task automatic add_write(input icp_pkg::reg_idx_t idx, input int val);
    req_t q;
    q = '{act: ACT_WRITE, count: '0, idx: idx, data: 32'(val), gap: '0};
    req_q.push_back(q);
  endtask

  task automatic add_drain();
    req_t q;
    q = '{act: ACT_DRAIN, count: '0, idx: icp_pkg::REG_MAX_ITER, data: '0, gap: '0};
    req_q.push_back(q);
  endtask

  function automatic int pick_gap(input int pct);
    return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 15) : 0;
  endfunction

  function automatic int pick_count(input int mx);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return (mx == 0) ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, mx));
    if (sel == 6) return $urandom_range(0, 65535);
    if (sel == 7) return mx;
    if (sel == 8) return (mx >= 65535) ? 65535 : int'($urandom_range(mx + 1, 65535));
    return $urandom_range(0, 3);
  endfunction

  initial begin
    int mx, n, pct, ph, i;
    // directed: reset settings, clamping, every mode, extreme maxima
    add_pixel(0, 0);
    add_pixel(1, pick_gap(20));
    add_pixel(50, 0);
    add_pixel(99, pick_gap(20));
    add_pixel(100, 0);
    add_pixel(101, 0);
    add_pixel(65535, pick_gap(20));
    add_pixel(16'h5555, 0);
    add_pixel(16'hAAAA, 0);
    for (i = 0; i < 8; i++) begin
      add_write(icp_pkg::REG_COLOR_MODE, i);
      add_pixel(30, pick_gap(20));
    end
    add_write(icp_pkg::REG_MAX_ITER, 0);
    add_pixel(0, 0);
    add_pixel(65535, 0);
    add_write(icp_pkg::REG_MAX_ITER, 65535);
    add_pixel(65535, 0);
    add_pixel(32768, 0);
    add_pixel(1, 0);
    add_write(icp_pkg::REG_MAX_ITER, 1);
    add_pixel(0, 0);
    add_pixel(1, 0);

    for (ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0:       mx = 65535;
        1:       mx = 1;
        2:       mx = $urandom_range(2, 255);
        3:       mx = $urandom_range(256, 65534);
        4:       mx = 0;
        default: mx = 100;
      endcase
      add_write(icp_pkg::REG_MAX_ITER, mx);
      add_write(icp_pkg::REG_COLOR_MODE, (ph < 8) ? ph : int'($urandom_range(0, 7)));
      case (ph % 4)
        0:       pct = 0;
        1:       pct = 10;
        2:       pct = 30;
        default: pct = 60;
      endcase
      if (ph == 11) pct = 0;
      n = (mx < 2) ? 40 : 220;
      for (i = 0; i < n; i++) begin
        if (ph == 3 && i == n / 2) add_drain();
        add_pixel(pick_count(mx), pick_gap(pct));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (req_q.size() != 0 || start || psel || color_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (err_cnt == 0 && color_q.size() == 0) begin
      $display("tb_iteration_count_palette_top: done, clean");
    end else begin
      $display("tb_iteration_count_palette_top: done, errors");
    end
    $finish;
  end

endmodule
